[hdl/daf_pkg.sv]
// Detection anchor filter package: widths, configuration register indexes
// and the structs passed between the score tracker and the top level.
// No dependencies.
`default_nettype none

package daf_pkg;

  localparam int FRAC_SHIFT = 21;
  localparam int EDGE_W     = 20;
  localparam int SCALE_W    = 24;
  localparam int PROD_W     = EDGE_W + SCALE_W + 1;
  localparam int QUOT_W     = PROD_W - FRAC_SHIFT;
  localparam int COORD_W    = 14;

  typedef enum logic [2:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_PAD_LEFT        = 3'd1,
    REG_PAD_TOP         = 3'd2,
    REG_INVERSE_SCALE   = 3'd3,
    REG_FRAME_WIDTH     = 3'd4,
    REG_FRAME_HEIGHT    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] anchor_index;
    logic [7:0]  class_index;
    logic [15:0] confidence;
  } det_meta_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] left;
    logic signed [EDGE_W-1:0] top;
    logic signed [EDGE_W-1:0] right;
    logic signed [EDGE_W-1:0] bottom;
  } edge_set_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] left;
    logic signed [PROD_W-1:0] top;
    logic signed [PROD_W-1:0] right;
    logic signed [PROD_W-1:0] bottom;
  } prod_set_t;

endpackage

`default_nettype wire

[hdl/daf_score_track.sv]
// Score tracker: running best score and class per anchor, anchor counter,
// and the first pipeline register holding padded-removed edges. Uses daf_pkg.
`default_nettype none

module daf_score_track import daf_pkg::*; #(
  parameter int MAX_CLASSES = 256,
  parameter int MAX_ANCHORS = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [15:0]       class_score,
  input  wire logic              score_invalid,
  input  wire logic [15:0]       center_x,
  input  wire logic [15:0]       center_y,
  input  wire logic [15:0]       box_width,
  input  wire logic [15:0]       box_height,
  input  wire logic              last_class,
  input  wire logic [15:0]       score_threshold,
  input  wire logic [11:0]       pad_left,
  input  wire logic [11:0]       pad_top,
  input  wire logic              take,
  output      logic              stage_valid,
  output      det_meta_t         stage_meta,
  output      edge_set_t         stage_edges
);

  localparam logic [7:0]  CLASS_LAST  = 8'(MAX_CLASSES - 1);
  localparam logic [15:0] ANCHOR_LAST = 16'(MAX_ANCHORS - 1);

  logic [15:0] running_best;
  logic [7:0]  running_class;
  logic [7:0]  class_position;
  logic        saw_invalid;
  logic [15:0] anchor_position;

  logic        accept;
  logic        replace;
  logic [15:0] best_next;
  logic [7:0]  class_next;
  logic        invalid_next;
  logic        keep;
  logic [EDGE_W-1:0] cx2, cy2, bw, bh, px, py;

  assign in_ready = !stage_valid || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    replace      = (class_position == 8'd0) || (class_score > running_best);
    best_next    = replace ? class_score : running_best;
    class_next   = replace ? class_position : running_class;
    invalid_next = saw_invalid || score_invalid;
    keep         = !invalid_next && (best_next >= score_threshold);
    cx2          = {3'b000, center_x, 1'b0};
    cy2          = {3'b000, center_y, 1'b0};
    bw           = {4'b0000, box_width};
    bh           = {4'b0000, box_height};
    px           = {3'b000, pad_left, 5'b00000};
    py           = {3'b000, pad_top, 5'b00000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_best    <= '0;
      running_class   <= '0;
      class_position  <= '0;
      saw_invalid     <= 1'b0;
      anchor_position <= '0;
    end else if (accept) begin
      if (last_class) begin
        running_best    <= '0;
        running_class   <= '0;
        class_position  <= '0;
        saw_invalid     <= 1'b0;
        anchor_position <= (anchor_position == ANCHOR_LAST) ? 16'd0 : anchor_position + 16'd1;
      end else begin
        running_best   <= best_next;
        running_class  <= class_next;
        saw_invalid    <= invalid_next;
        if (class_position < CLASS_LAST) begin
          class_position <= class_position + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= accept && last_class && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_class) begin
      stage_meta.anchor_index <= anchor_position;
      stage_meta.class_index  <= class_next;
      stage_meta.confidence   <= best_next;
      stage_edges.left        <= $signed(cx2 - bw - px);
      stage_edges.right       <= $signed(cx2 + bw - px);
      stage_edges.top         <= $signed(cy2 - bh - py);
      stage_edges.bottom      <= $signed(cy2 + bh - py);
    end
  end

endmodule

`default_nettype wire

[hdl/daf_edge_map.sv]
// Edge mapper: floor or ceil of a scaled edge by 2^21, clamped to [0, bound].
// Uses daf_pkg.
`default_nettype none

module daf_edge_map import daf_pkg::*; #(
  parameter bit CEIL_MODE = 1'b0
) (
  input  wire logic signed [PROD_W-1:0] prod,
  input  wire logic [COORD_W-1:0]       bound,
  output      logic [COORD_W-1:0]       edge_pix
);

  localparam logic signed [PROD_W-1:0] ROUND_ADD =
    CEIL_MODE ? PROD_W'((64'd1 << FRAC_SHIFT) - 64'd1) : '0;

  logic signed [PROD_W-1:0] adjusted;
  logic signed [QUOT_W-1:0] quot;
  logic signed [QUOT_W-1:0] bound_ext;

  always_comb begin
    adjusted  = prod + ROUND_ADD;
    quot      = QUOT_W'(adjusted >>> FRAC_SHIFT);
    bound_ext = $signed({{(QUOT_W - COORD_W){1'b0}}, bound});
    if (quot < 0) begin
      edge_pix = '0;
    end else if (quot > bound_ext) begin
      edge_pix = bound;
    end else begin
      edge_pix = quot[COORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/detection_anchor_filter.sv]
// Detection anchor filter top level: configuration registers, scale multiply
// stage and result register. Uses daf_pkg, daf_score_track and daf_edge_map.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one class score per transaction;
//   last_class marks the final score of an anchor, and the box fields are
//   sampled with that transaction only.
//   Output channel (out_valid/out_ready) carries at most one detection per
//   anchor: anchors with a flagged score, a best score below the threshold
//   or an empty clamped box produce nothing but still use up an index.
//   Throughput: one transaction per cycle, sustained while in_ready is high, set by the
//   single compare-and-select of the running maximum.
//   Pipeline: a detection passes the tracker register, the 20x25 multiply
//   register and the result register after its last score is accepted.
//   Stall: when out_ready is low, the result holds and the two earlier
//   stages keep filling; in_ready falls only when all three stages are full.
//   Reset (rst, synchronous): clears the running maximum, the anchor count,
//   all stage valids and loads the register defaults.
//   Configuration writes (cfg_write_en, cfg_index, cfg_wdata) take effect at
//   once; the user must make them only while the block is idle (not enforced).
`default_nettype none

module detection_anchor_filter import daf_pkg::*; #(
  parameter int MAX_CLASSES = 256,
  parameter int MAX_ANCHORS = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [15:0]        class_score,
  input  wire logic               score_invalid,
  input  wire logic [15:0]        center_x,
  input  wire logic [15:0]        center_y,
  input  wire logic [15:0]        box_width,
  input  wire logic [15:0]        box_height,
  input  wire logic               last_class,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [15:0]        anchor_index,
  output      logic [7:0]         class_index,
  output      logic [15:0]        confidence,
  output      logic [COORD_W-1:0] edge_left,
  output      logic [COORD_W-1:0] edge_top,
  output      logic [COORD_W-1:0] edge_right,
  output      logic [COORD_W-1:0] edge_bottom
);

  logic [15:0]        score_threshold;
  logic [11:0]        pad_left;
  logic [11:0]        pad_top;
  logic [SCALE_W-1:0] inverse_scale;
  logic [COORD_W-1:0] frame_width;
  logic [COORD_W-1:0] frame_height;

  logic      s1_valid;
  det_meta_t s1_meta;
  edge_set_t s1_edges;
  logic      s2_valid;
  det_meta_t s2_meta;
  prod_set_t s2_prods;
  logic      s2_ready;
  logic      s3_ready;

  logic signed [SCALE_W:0] scale_s;
  logic [COORD_W-1:0] map_left, map_top, map_right, map_bottom;
  logic               box_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= 16'd16384;
      pad_left        <= '0;
      pad_top         <= '0;
      inverse_scale   <= SCALE_W'(65536);
      frame_width     <= COORD_W'(640);
      frame_height    <= COORD_W'(640);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SCORE_THRESHOLD: score_threshold <= cfg_wdata[15:0];
        REG_PAD_LEFT:        pad_left        <= cfg_wdata[11:0];
        REG_PAD_TOP:         pad_top         <= cfg_wdata[11:0];
        REG_INVERSE_SCALE:   inverse_scale   <= cfg_wdata[SCALE_W-1:0];
        REG_FRAME_WIDTH:     frame_width     <= cfg_wdata[COORD_W-1:0];
        REG_FRAME_HEIGHT:    frame_height    <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;

  daf_score_track #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_ANCHORS (MAX_ANCHORS)
  ) u_track (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .class_score     (class_score),
    .score_invalid   (score_invalid),
    .center_x        (center_x),
    .center_y        (center_y),
    .box_width       (box_width),
    .box_height      (box_height),
    .last_class      (last_class),
    .score_threshold (score_threshold),
    .pad_left        (pad_left),
    .pad_top         (pad_top),
    .take            (s2_ready),
    .stage_valid     (s1_valid),
    .stage_meta      (s1_meta),
    .stage_edges     (s1_edges)
  );

  assign scale_s = $signed({1'b0, inverse_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_meta         <= s1_meta;
      s2_prods.left   <= s1_edges.left * scale_s;
      s2_prods.top    <= s1_edges.top * scale_s;
      s2_prods.right  <= s1_edges.right * scale_s;
      s2_prods.bottom <= s1_edges.bottom * scale_s;
    end
  end

  daf_edge_map #(.CEIL_MODE(1'b0)) u_map_left (
    .prod (s2_prods.left), .bound (frame_width), .edge_pix (map_left)
  );
  daf_edge_map #(.CEIL_MODE(1'b0)) u_map_top (
    .prod (s2_prods.top), .bound (frame_height), .edge_pix (map_top)
  );
  daf_edge_map #(.CEIL_MODE(1'b1)) u_map_right (
    .prod (s2_prods.right), .bound (frame_width), .edge_pix (map_right)
  );
  daf_edge_map #(.CEIL_MODE(1'b1)) u_map_bottom (
    .prod (s2_prods.bottom), .bound (frame_height), .edge_pix (map_bottom)
  );

  assign box_ok = (map_right > map_left) && (map_bottom > map_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid && box_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      anchor_index <= s2_meta.anchor_index;
      class_index  <= s2_meta.class_index;
      confidence   <= s2_meta.confidence;
      edge_left    <= map_left;
      edge_top     <= map_top;
      edge_right   <= map_right;
      edge_bottom  <= map_bottom;
    end
  end

endmodule

`default_nettype wire

[hdl/daf_checker.sv]
// Port-level checker for the detection anchor filter, bound to the top level.
// Uses daf_pkg for the coordinate width.
`default_nettype none

module daf_checker import daf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [15:0]        anchor_index,
  input wire logic [7:0]         class_index,
  input wire logic [15:0]        confidence,
  input wire logic [COORD_W-1:0] edge_left,
  input wire logic [COORD_W-1:0] edge_top,
  input wire logic [COORD_W-1:0] edge_right,
  input wire logic [COORD_W-1:0] edge_bottom
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(anchor_index) &&
      $stable(class_index) && $stable(confidence) && $stable(edge_left) &&
      $stable(edge_top) && $stable(edge_right) && $stable(edge_bottom))
    else $error("stalled detection changed");

  a_box_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_right > edge_left) && (edge_bottom > edge_top))
    else $error("empty box delivered");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("detection valid after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind detection_anchor_filter daf_checker u_daf_checker (.*);

`default_nettype wire

[verif/detection_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for detection_anchor_filter: tracks the register file, predicts each kept
// detection from the accepted score transactions and compares every output transaction.
// Depends on daf_pkg.
module detection_checker import daf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [15:0]        class_score,
  input  wire logic               score_invalid,
  input  wire logic [15:0]        center_x,
  input  wire logic [15:0]        center_y,
  input  wire logic [15:0]        box_width,
  input  wire logic [15:0]        box_height,
  input  wire logic               last_class,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [15:0]        anchor_index,
  input  wire logic [7:0]         class_index,
  input  wire logic [15:0]        confidence,
  input  wire logic [COORD_W-1:0] edge_left,
  input  wire logic [COORD_W-1:0] edge_top,
  input  wire logic [COORD_W-1:0] edge_right,
  input  wire logic [COORD_W-1:0] edge_bottom,
  output int                      errors,
  output int                      outstanding,
  output int                      compared
);

  localparam int         FRAC_BITS   = 21;
  localparam int         MAX_REPORTS = 10;
  localparam logic [7:0] LAST_SLOT   = 8'd255;

  typedef struct packed {
    logic [15:0]        anchor;
    logic [7:0]         cls;
    logic [15:0]        conf;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } detection_t;

  detection_t awaited[$];

  logic [15:0]        thr_q;
  logic [11:0]        pad_l_q;
  logic [11:0]        pad_t_q;
  logic [23:0]        scale_q;
  logic [COORD_W-1:0] fw_q;
  logic [COORD_W-1:0] fh_q;

  logic [15:0] top_score;
  logic [7:0]  top_class;
  logic [7:0]  class_slot;
  logic        flagged;
  logic [15:0] anchor_seq;

  // edge32 is in 1/32 network pixels; floor or ceil after the Q8.16 scale
  function automatic logic [COORD_W-1:0] to_source(input longint edge32, input logic [11:0] pad,
                                                   input logic [COORD_W-1:0] bound,
                                                   input bit round_up);
    longint prod;
    prod = (edge32 - 32 * longint'(pad)) * longint'(scale_q);
    if (round_up) prod = prod + (longint'(1) << FRAC_BITS) - 1;
    prod = prod >>> FRAC_BITS;
    if (prod < 0) prod = 0;
    if (prod > longint'(bound)) prod = longint'(bound);
    return prod[COORD_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    detection_t det;
    detection_t got;
    detection_t want;
    if (rst) begin
      thr_q       = 16'd16384;
      pad_l_q     = 12'd0;
      pad_t_q     = 12'd0;
      scale_q     = 24'd65536;
      fw_q        = 14'd640;
      fh_q        = 14'd640;
      top_score   = 16'd0;
      top_class   = 8'd0;
      class_slot  = 8'd0;
      flagged     = 1'b0;
      anchor_seq  = 16'd0;
      errors      = 0;
      compared    = 0;
      awaited.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SCORE_THRESHOLD: thr_q   = cfg_wdata[15:0];
          REG_PAD_LEFT:        pad_l_q = cfg_wdata[11:0];
          REG_PAD_TOP:         pad_t_q = cfg_wdata[11:0];
          REG_INVERSE_SCALE:   scale_q = cfg_wdata[23:0];
          REG_FRAME_WIDTH:     fw_q    = cfg_wdata[COORD_W-1:0];
          REG_FRAME_HEIGHT:    fh_q    = cfg_wdata[COORD_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = '{anchor_index, class_index, confidence,
                edge_left, edge_top, edge_right, edge_bottom};
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"unexpected detection: anchor %0d class %0d conf %0d",
                      " box %0d %0d %0d %0d"},
                     got.anchor, got.cls, got.conf, got.left, got.top, got.right, got.bottom);
        end else begin
          want = awaited.pop_front();
          compared++;
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display({"detection mismatch, expected anchor %0d class %0d conf %0d",
                        " box %0d %0d %0d %0d"},
                       want.anchor, want.cls, want.conf,
                       want.left, want.top, want.right, want.bottom);
              $display({"                    actual   anchor %0d class %0d conf %0d",
                        " box %0d %0d %0d %0d"},
                       got.anchor, got.cls, got.conf, got.left, got.top, got.right, got.bottom);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        if (class_slot == 8'd0 || class_score > top_score) begin
          top_score = class_score;
          top_class = class_slot;
        end
        if (score_invalid) flagged = 1'b1;
        if (class_slot != LAST_SLOT) class_slot = class_slot + 8'd1;
        if (last_class) begin
          if (!flagged && top_score >= thr_q) begin
            det.anchor = anchor_seq;
            det.cls    = top_class;
            det.conf   = top_score;
            det.left   = to_source(2 * longint'(center_x) - longint'(box_width),
                                   pad_l_q, fw_q, 1'b0);
            det.top    = to_source(2 * longint'(center_y) - longint'(box_height),
                                   pad_t_q, fh_q, 1'b0);
            det.right  = to_source(2 * longint'(center_x) + longint'(box_width),
                                   pad_l_q, fw_q, 1'b1);
            det.bottom = to_source(2 * longint'(center_y) + longint'(box_height),
                                   pad_t_q, fh_q, 1'b1);
            if (det.right > det.left && det.bottom > det.top) awaited = {awaited, det};
          end
          anchor_seq = anchor_seq + 16'd1;
          top_score  = 16'd0;
          top_class  = 8'd0;
          class_slot = 8'd0;
          flagged    = 1'b0;
        end
      end
    end
    outstanding = awaited.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for detection_anchor_filter: clock, reset, register setup, score stimulus
// with bursty input and stalling output, and the verdict.
// Depends on daf_pkg, detection_checker and the detection_anchor_filter RTL.
module tb_top;
  import daf_pkg::*;

  localparam logic [2:0] REG_SPARE    = 3'd6;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         RX_OPEN      = 0;
  localparam int         RX_CHOPPY    = 1;
  localparam int         RX_SPARSE    = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_write_en  = 1'b0;
  logic [2:0]  cfg_index     = 3'd0;
  logic [23:0] cfg_wdata     = 24'd0;
  logic        in_valid      = 1'b0;
  logic [15:0] class_score   = 16'd0;
  logic        score_invalid = 1'b0;
  logic [15:0] center_x      = 16'd0;
  logic [15:0] center_y      = 16'd0;
  logic [15:0] box_width     = 16'd0;
  logic [15:0] box_height    = 16'd0;
  logic        last_class    = 1'b0;
  logic        out_ready     = 1'b0;

  logic               in_ready;
  logic               out_valid;
  logic [15:0]        anchor_index;
  logic [7:0]         class_index;
  logic [15:0]        confidence;
  logic [COORD_W-1:0] edge_left;
  logic [COORD_W-1:0] edge_top;
  logic [COORD_W-1:0] edge_right;
  logic [COORD_W-1:0] edge_bottom;

  int errors;
  int outstanding;
  int compared;

  logic [15:0]        cur_thr   = 16'd16384;
  logic [11:0]        cur_pl    = 12'd0;
  logic [11:0]        cur_pt    = 12'd0;
  logic [23:0]        cur_scale = 24'd65536;
  logic [COORD_W-1:0] cur_fw    = 14'd640;
  logic [COORD_W-1:0] cur_fh    = 14'd640;

  bit gaps_on          = 1'b1;
  int burst_left       = 0;
  int items_sent       = 0;
  int anchors_sent     = 0;
  int settings_used    = 0;
  int holds_requested  = 0;
  int holds_done       = 0;
  int hold_left        = 0;
  int rx_left          = 0;
  int rx_mode          = RX_OPEN;

  detection_anchor_filter u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .class_score  (class_score),
    .score_invalid(score_invalid),
    .center_x     (center_x),
    .center_y     (center_y),
    .box_width    (box_width),
    .box_height   (box_height),
    .last_class   (last_class),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .anchor_index (anchor_index),
    .class_index  (class_index),
    .confidence   (confidence),
    .edge_left    (edge_left),
    .edge_top     (edge_top),
    .edge_right   (edge_right),
    .edge_bottom  (edge_bottom)
  );

  detection_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .class_score  (class_score),
    .score_invalid(score_invalid),
    .center_x     (center_x),
    .center_y     (center_y),
    .box_width    (box_width),
    .box_height   (box_height),
    .last_class   (last_class),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .anchor_index (anchor_index),
    .class_index  (class_index),
    .confidence   (confidence),
    .edge_left    (edge_left),
    .edge_top     (edge_top),
    .edge_right   (edge_right),
    .edge_bottom  (edge_bottom),
    .errors       (errors),
    .outstanding  (outstanding),
    .compared     (compared)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: long hold on request, otherwise segments of open, choppy or sparse ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_requested != holds_done) begin
      holds_done <= holds_requested;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_left <= $urandom_range(40, 4);
        rx_mode <= $urandom_range(RX_SPARSE, RX_OPEN);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= 1'($urandom_range(1, 0));
        default:   out_ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_wdata    <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [11:0] pl, input logic [11:0] pt,
                            input logic [23:0] sc, input logic [COORD_W-1:0] fw,
                            input logic [COORD_W-1:0] fh, input bit junk);
    write_reg(REG_SCORE_THRESHOLD, {junk ? 8'($urandom) : 8'h00, thr});
    write_reg(REG_PAD_LEFT, {junk ? 12'($urandom) : 12'h000, pl});
    write_reg(REG_PAD_TOP, {junk ? 12'($urandom) : 12'h000, pt});
    write_reg(REG_INVERSE_SCALE, sc);
    write_reg(REG_FRAME_WIDTH, {junk ? 10'($urandom) : 10'h000, fw});
    write_reg(REG_FRAME_HEIGHT, {junk ? 10'($urandom) : 10'h000, fh});
    if (junk) write_reg(REG_SPARE, 24'($urandom));
    cfg_write_en <= 1'b0;
    cur_thr   = thr;
    cur_pl    = pl;
    cur_pt    = pt;
    cur_scale = sc;
    cur_fw    = fw;
    cur_fh    = fh;
    settings_used++;
  endtask

  task automatic offer(input logic [15:0] score, input logic bad, input logic last,
                       input logic [15:0] cx, input logic [15:0] cy,
                       input logic [15:0] bw, input logic [15:0] bh);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    class_score   <= score;
    score_invalid <= bad;
    last_class    <= last;
    center_x      <= cx;
    center_y      <= cy;
    box_width     <= bw;
    box_height    <= bh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
    if (last) anchors_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly boxes that land inside the current frame, some full-range noise
  task automatic make_box(input bit tidy, output logic [15:0] cx, output logic [15:0] cy,
                          output logic [15:0] bw, output logic [15:0] bh);
    longint span_x;
    longint span_y;
    if (!tidy && $urandom_range(4, 0) == 0) begin
      cx = 16'($urandom);
      cy = 16'($urandom);
      bw = 16'($urandom);
      bh = 16'($urandom);
    end else begin
      span_x = (cur_scale == 24'd0) ? 4095 : (longint'(cur_fw) * 65536) / longint'(cur_scale);
      span_y = (cur_scale == 24'd0) ? 4095 : (longint'(cur_fh) * 65536) / longint'(cur_scale);
      if (span_x > 4095 - longint'(cur_pl)) span_x = 4095 - longint'(cur_pl);
      if (span_y > 4095 - longint'(cur_pt)) span_y = 4095 - longint'(cur_pt);
      if (span_x < 1) span_x = 1;
      if (span_y < 1) span_y = 1;
      cx = 16'((longint'(cur_pl) + $urandom_range(int'(span_x), 0)) * 16 +
               $urandom_range(15, 0));
      cy = 16'((longint'(cur_pt) + $urandom_range(int'(span_y), 0)) * 16 +
               $urandom_range(15, 0));
      bw = 16'($urandom_range(int'(span_x) * 16, 0));
      bh = 16'($urandom_range(int'(span_y) * 16, 0));
    end
  endtask

  task automatic send_anchor(input int n_cls, input bit ramp, input bit keep);
    logic [15:0] score;
    logic [15:0] prev;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] bw;
    logic [15:0] bh;
    logic        bad;
    int          pick;
    int          near;
    prev = 16'd0;
    for (int k = 0; k < n_cls; k++) begin
      pick = $urandom_range(9, 0);
      near = cur_thr;
      near = near + int'($urandom_range(2, 0)) - 1;
      if (near < 0) near = 0;
      if (near > 65535) near = 65535;
      if (keep) score = 16'hFFFF;
      else if (ramp) score = 16'(k * 251);
      else if (pick < 4) score = 16'($urandom);
      else if (pick < 7) score = 16'(near);
      else if (pick < 9 && k > 0) score = prev;
      else score = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
      bad = !keep && ($urandom_range(24, 0) == 0);
      if (k == n_cls - 1) begin
        make_box(keep, cx, cy, bw, bh);
      end else begin
        cx = 16'($urandom);
        cy = 16'($urandom);
        bw = 16'($urandom);
        bh = 16'($urandom);
      end
      offer(score, bad, k == n_cls - 1, cx, cy, bw, bh);
      prev = score;
    end
  endtask

  task automatic random_traffic(input int quota, input bit pause_midway);
    int start;
    int n;
    bit paused;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < quota) begin
      n = $urandom_range(9, 0);
      if (n < 7) n = $urandom_range(4, 1);
      else n = $urandom_range(24, 5);
      send_anchor(n, 1'b0, 1'b0);
      if (pause_midway && !paused && items_sent - start >= quota / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: ties, flags, threshold edge, clamping, fractional centers
    offer(16'hFFFF, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'h0000, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'd100, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'd30000, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(16'd30000, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'd40000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'd50000, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'd100, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'd16384, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'd16383, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(16'hFFFF, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'd50000, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'd60000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'd20000, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer(16'd1000, 1'b0, 1'b1, 16'h0105, 16'h0105, 16'h0000, 16'h0000);
    offer(16'd20000, 1'b0, 1'b1, 16'd10080, 16'd10080, 16'd640, 16'd640);
    offer(16'hFFFF, 1'b1, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    drain();

    // register extremes: full padding and scale, widest frame, strictest threshold, then zero and minimal settings
    set_config(16'hFFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 14'h3FFF, 14'h3FFF, 1'b0);
    offer(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(16'hFFFE, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    drain();
    set_config(16'h0000, 12'h000, 12'h000, 24'h000000, 14'd0, 14'd0, 1'b0);
    offer(16'h0000, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    offer(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    set_config(16'h0000, 12'h000, 12'h000, 24'd65536, 14'd0, 14'h3FFF, 1'b0);
    offer(16'h0000, 1'b0, 1'b1, 16'd1600, 16'd1600, 16'd320, 16'd320);
    drain();
    set_config(16'h0000, 12'h000, 12'h000, 24'd1, 14'd1, 14'd1, 1'b0);
    offer(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // long output hold while input keeps coming, then a saturating class count
    set_config(16'd16384, 12'd0, 12'd0, 24'd65536, 14'd640, 14'd640, 1'b1);
    holds_requested++;
    random_traffic(200, 1'b0);
    send_anchor(260, 1'b1, 1'b0);
    drain();

    set_config(16'($urandom), 12'($urandom_range(200, 0)), 12'($urandom_range(200, 0)),
               24'($urandom_range(262144, 32768)), 14'($urandom_range(8192, 1)),
               14'($urandom_range(8192, 1)), 1'b1);
    random_traffic(200, 1'b1);
    send_anchor($urandom_range(268, 257), 1'b0, 1'b0);
    drain();

    set_config(16'h0000, 12'hFFF, 12'hFFF, 24'hFFFFFF, 14'd8192, 14'd8192, 1'b0);
    random_traffic(150, 1'b0);
    drain();

    set_config(16'($urandom_range(40000, 0)), 12'($urandom), 12'($urandom), 24'($urandom),
               14'($urandom), 14'($urandom), 1'b1);
    random_traffic(200, 1'b0);
    drain();

    set_config(16'($urandom_range(50000, 0)), 12'($urandom_range(64, 0)),
               12'($urandom_range(64, 0)), 24'($urandom_range(262144, 32768)),
               14'($urandom_range(8192, 1)), 14'($urandom_range(8192, 1)), 1'b1);
    random_traffic(200, 1'b0);
    drain();

    $display("Run covered %0d score transactions in %0d anchors under %0d register settings,",
             items_sent, anchors_sent, settings_used);
    $display("with bursty input, stalled output and saturated class counts; %0d detections compared.",
             compared);
    if (errors == 0 && outstanding == 0) begin
      $display("[detection_anchor_filter] OK");
    end else begin
      $display("[detection_anchor_filter] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[detection_anchor_filter] ERROR");
    $finish;
  end

endmodule

[sim.f]
hdl/daf_pkg.sv
hdl/daf_score_track.sv
hdl/daf_edge_map.sv
hdl/detection_anchor_filter.sv
hdl/daf_checker.sv
verif/detection_checker.sv
verif/tb_top.sv
